@@ design/kim_pkg.sv @@
// Shared constants, keyword table and helper function for the keyword intent matcher.
package kim_pkg;

    localparam int MAX_QUERY_BYTES = 1024;
    localparam int NUM_KEYWORDS    = 12;
    localparam int WINDOW_BYTES    = 7;

    localparam int TABLE_SIZE  = 12;
    localparam int KW_MAX      = 7;
    localparam int ACTIVE_KW   = (NUM_KEYWORDS < TABLE_SIZE) ? NUM_KEYWORDS : TABLE_SIZE;
    localparam int HIST_DEPTH  = WINDOW_BYTES - 1;
    localparam int CNT_W       = $clog2(MAX_QUERY_BYTES);
    localparam int IDX_W       = 4;
    localparam int CLASS_W     = 3;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    typedef logic [7:0]            byte_t;
    typedef logic [ACTIVE_KW-1:0]  kw_flags_t;
    typedef logic [KW_MAX*8-1:0]   kw_row_t;

    // Byte 0 of each keyword sits in the low bits.
    localparam kw_row_t KW_TEXT [TABLE_SIZE] = '{
        56'h0000_0000_0000_6361,   // ac
        56'h0000_0000_A7C3_61,     // a c-cedilla
        56'h0000_616C_6761_62,     // bagla
        56'h0061_6C9F_C461_62,     // ba g-breve la
        56'h0000_0000_7275_71,     // qur
        56'h0000_0000_7275_6B,     // kur
        56'h6C6C_6174_736E_69,     // install
        56'h0000_0000_6C69_73,     // sil
        56'h0065_766F_6D65_72,     // remove
        56'h0000_0000_6172_61,     // ara
        56'h0068_6372_6165_73,     // search
        56'h0000_0069_6669_77      // wifi
    };

    localparam int KW_LEN [TABLE_SIZE] = '{2, 3, 5, 6, 3, 3, 7, 3, 6, 3, 6, 4};

    localparam logic [CLASS_W-1:0] KW_CLASS [TABLE_SIZE] = '{
        3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5
    };

    function automatic byte_t kw_byte(input int k, input int pos);
        kw_row_t row;
        row = KW_TEXT[k];
        return row[8*pos +: 8];
    endfunction

endpackage

@@ design/kim_window_match.sv @@
// Parallel comparison of the byte window against every active keyword.
module kim_window_match (
    input  kim_pkg::byte_t                         cur_byte,
    input  logic [kim_pkg::HIST_DEPTH-1:0][7:0]    hist,
    output kim_pkg::kw_flags_t                     hits
);

    kim_pkg::byte_t win [kim_pkg::WINDOW_BYTES];

    always_comb begin
        win[0] = cur_byte;
        for (int j = 1; j < kim_pkg::WINDOW_BYTES; j++) begin
            win[j] = hist[j-1];
        end
    end

    for (genvar k = 0; k < kim_pkg::ACTIVE_KW; k++) begin : g_kw
        localparam int L = kim_pkg::KW_LEN[k];

        always_comb begin
            logic ok;
            ok = (L <= kim_pkg::WINDOW_BYTES) && (L > 0);
            for (int j = 0; j < kim_pkg::WINDOW_BYTES; j++) begin
                if (j < L && j < kim_pkg::KW_MAX) begin
                    if (win[j] != kim_pkg::kw_byte(k, L - 1 - j)) begin
                        ok = 1'b0;
                    end
                end
            end
            hits[k] = ok;
        end
    end

endmodule

@@ design/keyword_intent_matcher.sv @@
// Top level of the keyword intent matcher: input stage, scan state and result register.
// The byte marked last passes through the input register; the result register loads
//   when that byte leaves the input stage, and the result is then held until taken.
// Throughput: one byte per cycle while no byte marked last waits on an untaken result;
//   the window compare against all keywords in kim_window_match is combinational.
// A waiting result does not block the input: non-last bytes keep flowing.
// Reset (aresetn low, synchronous): empties the input and result stages and
//   clears the window, found flags, byte count and scan-ended flag.
module keyword_intent_matcher (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_query_byte,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_matched,
    output logic [kim_pkg::IDX_W-1:0]       m_keyword_index,
    output logic [kim_pkg::CLASS_W-1:0]     m_capability_code
);

    // Input stage
    logic                 in_valid_reg;
    kim_pkg::byte_t       in_byte_reg;
    logic                 in_last_reg;

    // Scan state
    logic [kim_pkg::HIST_DEPTH-1:0][7:0] hist_reg, hist_next;
    kim_pkg::kw_flags_t                  found_reg, found_next;
    logic [kim_pkg::CNT_W-1:0]           count_reg, count_next;
    logic                                ended_reg, ended_next;

    // Result register
    logic                                m_valid_reg, m_valid_next;
    logic                                matched_reg, matched_next;
    logic [kim_pkg::IDX_W-1:0]           index_reg, index_next;
    logic [kim_pkg::CLASS_W-1:0]         class_reg, class_next;

    logic                 out_free;
    logic                 advance;
    logic                 scan;
    kim_pkg::byte_t       folded;
    kim_pkg::kw_flags_t   hits;
    kim_pkg::kw_flags_t   flags_all;

    // The result slot frees up when empty or being taken this cycle.
    assign out_free = !m_valid_reg || m_ready;
    // A non-last byte never needs the result slot, so it always moves on.
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    // Fold ASCII capitals to lower case.
    always_comb begin
        if (in_byte_reg >= kim_pkg::CHAR_UPPER_A && in_byte_reg <= kim_pkg::CHAR_UPPER_Z) begin
            folded = in_byte_reg + kim_pkg::CASE_OFFSET;
        end else begin
            folded = in_byte_reg;
        end
    end

    // Scan the byte only while the scan is live, the byte is not the
    // terminator and the length limit is not yet reached.
    assign scan = !ended_reg && (in_byte_reg != 8'd0)
                  && (count_reg < kim_pkg::CNT_W'(kim_pkg::MAX_QUERY_BYTES - 1));

    kim_window_match u_match (
        .cur_byte (folded),
        .hist     (hist_reg),
        .hits     (hits)
    );

    assign flags_all = found_reg | (scan ? hits : '0);

    // Scan state update: clear on the last byte, else shift and accumulate, or mark the scan ended.
    always_comb begin
        hist_next  = hist_reg;
        found_next = found_reg;
        count_next = count_reg;
        ended_next = ended_reg;
        if (advance) begin
            if (in_last_reg) begin
                hist_next  = '0;
                found_next = '0;
                count_next = '0;
                ended_next = 1'b0;
            end else if (scan) begin
                for (int j = kim_pkg::HIST_DEPTH - 1; j > 0; j--) begin
                    hist_next[j] = hist_reg[j-1];
                end
                hist_next[0] = folded;
                found_next   = flags_all;
                count_next   = count_reg + 1'b1;
            end else begin
                ended_next = 1'b1;
            end
        end
    end

    // Result: lowest table position among the found flags wins.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        matched_next = matched_reg;
        index_next   = index_reg;
        class_next   = class_reg;
        if (advance && in_last_reg) begin
            m_valid_next = 1'b1;
            matched_next = 1'b0;
            index_next   = '0;
            class_next   = '0;
            for (int k = kim_pkg::ACTIVE_KW - 1; k >= 0; k--) begin
                if (flags_all[k]) begin
                    matched_next = 1'b1;
                    index_next   = kim_pkg::IDX_W'(k);
                    class_next   = kim_pkg::KW_CLASS[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            hist_reg     <= '0;
            found_reg    <= '0;
            count_reg    <= '0;
            ended_reg    <= 1'b0;
        end else begin
            // Hold the input stage until it advances, then load the next transfer.
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            m_valid_reg <= m_valid_next;
            hist_reg    <= hist_next;
            found_reg   <= found_next;
            count_reg   <= count_next;
            ended_reg   <= ended_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_query_byte;
            in_last_reg <= s_last_byte;
        end
        matched_reg <= matched_next;
        index_reg   <= index_next;
        class_reg   <= class_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_matched         = matched_reg;
    assign m_keyword_index   = index_reg;
    assign m_capability_code = class_reg;

    // A result without a match reports position and class zero.
    a_nomatch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_matched |-> m_keyword_index == '0 && m_capability_code == '0)
        else $error("unmatched result carries nonzero index or class");

    // A reported position always lies within the active table.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_keyword_index < kim_pkg::IDX_W'(kim_pkg::ACTIVE_KW))
        else $error("keyword index beyond active table");

    // The last byte of a query leaves the scan state cleared.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> found_reg == '0 && count_reg == '0 && !ended_reg)
        else $error("scan state not cleared after last byte");

    // The byte count never passes the length limit.
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= kim_pkg::CNT_W'(kim_pkg::MAX_QUERY_BYTES - 1))
        else $error("byte count beyond length limit");

endmodule

@@ verif/keyword_intent_matcher_test.sv @@
// Self-checking testbench for the keyword intent matcher: directed, length-limit and random queries.
module keyword_intent_matcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Capability classes as the block reports them.
    typedef enum logic [kim_pkg::CLASS_W-1:0] {
        CAP_OPEN,
        CAP_CLOSE_APP,
        CAP_INSTALL,
        CAP_REMOVE,
        CAP_SEARCH,
        CAP_NETWORK
    } cap_t;

    typedef struct packed {
        logic                        matched;
        logic [kim_pkg::IDX_W-1:0]   index;
        logic [kim_pkg::CLASS_W-1:0] code;
    } verdict_t;

    localparam int PHRASE_COUNT = 12;
    localparam int TRAIL_DEPTH  = 6;      // window of 7 = current byte + 6 behind it
    localparam int SCAN_LIMIT   = 1023;   // bytes scanned before the length limit stops the scan
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 200;
    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] UPPER_A  = "A";
    localparam logic [7:0] UPPER_Z  = "Z";
    localparam logic [7:0] LOWER_A  = "a";
    localparam logic [7:0] LOWER_Z  = "z";
    localparam logic [7:0] CASE_GAP = 8'd32;
    localparam logic [7:0] NUL      = 8'h00;

    // Keyword text, first byte in the highest used lane, last byte in bits 7:0,
    // so lane j holds the byte j positions back from the newest one.
    localparam logic [55:0] PHRASE [PHRASE_COUNT] = '{
        56'("ac"),
        56'({8'h61, 8'hC3, 8'hA7}),
        56'("bagla"),
        56'({8'h62, 8'h61, 8'hC4, 8'h9F, 8'h6C, 8'h61}),
        56'("qur"),
        56'("kur"),
        56'("install"),
        56'("sil"),
        56'("remove"),
        56'("ara"),
        56'("search"),
        56'("wifi")
    };
    localparam int PHRASE_LEN [PHRASE_COUNT] = '{2, 3, 5, 6, 3, 3, 7, 3, 6, 3, 6, 4};
    localparam cap_t PHRASE_CAP [PHRASE_COUNT] = '{
        CAP_OPEN, CAP_OPEN, CAP_CLOSE_APP, CAP_CLOSE_APP, CAP_INSTALL, CAP_INSTALL,
        CAP_INSTALL, CAP_REMOVE, CAP_REMOVE, CAP_SEARCH, CAP_SEARCH, CAP_NETWORK
    };

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [7:0]                    s_query_byte = 8'h00;
    logic                          s_last_byte = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_matched;
    logic [kim_pkg::IDX_W-1:0]     m_keyword_index;
    logic [kim_pkg::CLASS_W-1:0]   m_capability_code;

    // Predictor copy of the scan state.
    logic [7:0]           trail [TRAIL_DEPTH];
    logic [PHRASE_COUNT-1:0] seen_flags;
    int                   scanned_bytes;
    bit                   scan_stopped;

    verdict_t             verdict_q [$];
    logic [7:0]           query_buf [$];

    bit                   idle_off = 1'b0;
    int                   mismatches = 0;
    int                   bytes_sent = 0;
    int                   queries_sent = 0;
    int                   verdicts_checked = 0;
    int                   matches_seen = 0;
    int                   cycle_count = 0;

    keyword_intent_matcher i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_query_byte      (s_query_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_matched         (m_matched),
        .m_keyword_index   (m_keyword_index),
        .m_capability_code (m_capability_code)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: fail and end the run if it has not finished by the cycle limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Clear the predictor for a new query: window zero-filled, no flags.
    task automatic clear_scan();
        for (int i = 0; i < TRAIL_DEPTH; i++) trail[i] = 8'h00;
        seen_flags = '0;
        scanned_bytes = 0;
        scan_stopped = 1'b0;
    endtask

    // Advance the predictor by one transferred byte; on the last byte queue
    // the verdict the block must report and start a fresh query.
    task automatic predict_byte(input logic [7:0] raw, input logic closing);
        logic [7:0]  ch;
        logic [55:0] row;
        bit          hit;
        verdict_t    v;
        if (!scan_stopped) begin
            if (raw == NUL || scanned_bytes >= SCAN_LIMIT) begin
                scan_stopped = 1'b1;
            end else begin
                ch = raw;
                if (ch >= UPPER_A && ch <= UPPER_Z) ch = ch + CASE_GAP;
                // Compare every keyword against the window, all in one step.
                for (int k = 0; k < PHRASE_COUNT; k++) begin
                    row = PHRASE[k];
                    hit = (row[7:0] == ch);
                    for (int j = 1; j < PHRASE_LEN[k]; j++) begin
                        if (row[8*j +: 8] != trail[j-1]) hit = 1'b0;
                    end
                    if (hit) seen_flags[k] = 1'b1;
                end
                for (int i = TRAIL_DEPTH - 1; i > 0; i--) trail[i] = trail[i-1];
                trail[0] = ch;
                scanned_bytes++;
            end
        end
        if (closing) begin
            v = '0;
            // Walk down so the lowest table position wins.
            for (int k = PHRASE_COUNT - 1; k >= 0; k--) begin
                if (seen_flags[k]) begin
                    v.matched = 1'b1;
                    v.index   = kim_pkg::IDX_W'(k);
                    v.code    = PHRASE_CAP[k];
                end
            end
            verdict_q.push_back(v);
            clear_scan();
        end
    endtask

    // Send one byte: idle for a drawn gap, then hold valid until the transfer.
    task automatic send_byte(input logic [7:0] value, input logic closing);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_query_byte <= value;
        s_last_byte  <= closing;
        do @(posedge aclk); while (!s_ready);
        predict_byte(value, closing);
        bytes_sent++;
        if (closing) queries_sent++;
    endtask

    // Send the buffered query, marking its final byte as last.
    task automatic send_query();
        for (int i = 0; i < query_buf.size(); i++) begin
            send_byte(query_buf[i], i == query_buf.size() - 1);
        end
        query_buf.delete();
    endtask

    task automatic append_text(input string text);
        for (int i = 0; i < text.len(); i++) query_buf.push_back(text[i]);
    endtask

    // Drop valid, then hold the sender until every queued verdict has been seen.
    task automatic drain_verdicts();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    // Append one keyword, each ASCII letter randomly upper-cased; a partial
    // keyword stops one byte short.
    task automatic append_phrase(input int k, input bit partial);
        logic [55:0] row;
        logic [7:0]  ch;
        int          count;
        row = PHRASE[k];
        count = partial ? PHRASE_LEN[k] - 1 : PHRASE_LEN[k];
        for (int j = 0; j < count; j++) begin
            ch = row[8*(PHRASE_LEN[k] - 1 - j) +: 8];
            if (ch >= LOWER_A && ch <= LOWER_Z && $urandom_range(0, 1)) ch = ch - CASE_GAP;
            query_buf.push_back(ch);
        end
    endtask

    task automatic test_directed();
        // Upper-case keyword folds to a match.
        append_text("AC");
        send_query();
        // Two-byte UTF-8 letter inside a keyword.
        query_buf = '{8'h61, 8'hC3, 8'hA7};
        send_query();
        // A zero byte stops the scan: the trailing 'a' must not complete "ara".
        query_buf = '{8'h61, 8'h72, NUL, 8'h61};
        send_query();
        // Lone extreme bytes, including a zero byte that is itself the last one.
        query_buf = '{8'hFF};
        send_query();
        query_buf = '{NUL};
        send_query();
        // A keyword split across two queries never matches.
        query_buf = '{8'h61};
        send_query();
        query_buf = '{8'h63};
        send_query();
        // Two keywords present: the earlier table entry is reported.
        append_text("wifiac");
        send_query();
    endtask

    task automatic test_length_limit();
        // "sil" ends on the last byte that may still be scanned; the "ac" after
        // it hits the limit and must not be reported.
        for (int i = 0; i < SCAN_LIMIT - 3; i++) query_buf.push_back("x");
        append_text("silac");
        send_query();
    endtask

    task automatic test_random();
        int start_bytes;
        int segments;
        int kind;
        int run;
        bit paused;
        start_bytes = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start_bytes < RANDOM_ITEMS) begin
            // Switch idling off for stretches so back-to-back transfers happen too.
            if ($urandom_range(0, 7) == 0) idle_off = !idle_off;
            segments = $urandom_range(1, 4);
            for (int s = 0; s < segments; s++) begin
                kind = $urandom_range(0, 9);
                if (kind <= 3) begin
                    append_phrase($urandom_range(0, PHRASE_COUNT - 1), 1'b0);
                end else if (kind == 4) begin
                    append_phrase($urandom_range(0, PHRASE_COUNT - 1), 1'b1);
                end else if (kind <= 7) begin
                    run = $urandom_range(1, 4);
                    repeat (run) query_buf.push_back(8'($urandom_range(8'h41, 8'h7A)));
                end else if (kind == 8) begin
                    query_buf.push_back(8'($urandom_range(0, 255)));
                end else begin
                    query_buf.push_back($urandom_range(0, 1) ? NUL : 8'($urandom_range(128, 255)));
                end
            end
            send_query();
            // Halfway through, stop sending until the block has emptied.
            if (!paused && bytes_sent - start_bytes >= RANDOM_ITEMS / 2) begin
                drain_verdicts();
                paused = 1'b1;
            end
        end
        idle_off = 1'b0;
    endtask

    // Result side: drop ready for a drawn stall before each transfer.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = idle_off ? 0 : $urandom_range(0, 16);
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each transferred verdict with the oldest prediction.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected verdict: matched %0d index %0d code %0d",
                             m_matched, m_keyword_index, m_capability_code);
            end else begin
                want = verdict_q.pop_front();
                verdicts_checked++;
                if (m_matched) matches_seen++;
                if (m_matched !== want.matched || m_keyword_index !== want.index ||
                    m_capability_code !== want.code) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("verdict mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.matched, want.index, want.code,
                                 m_matched, m_keyword_index, m_capability_code);
                end
            end
        end
    end

    initial begin
        clear_scan();
        // Hold reset, then release it at a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_length_limit();
        test_random();

        @(negedge aclk);
        s_valid <= 1'b0;
        drain_verdicts();
        // Let a late or extra verdict show up before judging.
        repeat (8) @(posedge aclk);
        if (verdict_q.size() != 0) begin
            mismatches++;
            $display("%0d predicted verdicts never arrived", verdict_q.size());
        end

        $display("sent %0d bytes in %0d queries; checked %0d verdicts, %0d with a keyword",
                 bytes_sent, queries_sent, verdicts_checked, matches_seen);
        $display("covered case folding, UTF-8 keywords, zero bytes, the length limit, idling");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/kim_pkg.sv
design/kim_window_match.sv
design/keyword_intent_matcher.sv
verif/keyword_intent_matcher_test.sv
